@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check: when ante holds, cons must hold (overlapping).
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle check: when ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Never check: cond must not hold.
`define ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("assertion failed: forbidden condition");

`endif

@@ hdl/vag_dec_pkg.sv @@
// ----------------------------------------------------------------------------
// VAG ADPCM decoder package
// Widths, stream codes, predictor coefficients and the decode command type.
// ----------------------------------------------------------------------------
package vag_dec_pkg;

   localparam int BYTE_W      = 8;
   localparam int PCM_W       = 16;
   localparam int IDX_W       = 11;
   localparam int HIST_W      = 30;
   localparam int HIST_FRAC   = 6;
   localparam int COEF_W      = 8;
   localparam int POS_W       = 4;
   localparam int PRED_W      = 3;
   localparam int SHIFT_W     = 4;
   localparam int NIB_W       = 4;

   localparam int SAMPLES_PER_BLOCK      = 28;
   localparam int BLOCKS_PER_CHANNEL_DEF = 64;

   // byte positions inside a 16-byte block
   localparam logic [POS_W-1:0] POS_HEADER = 4'd0;
   localparam logic [POS_W-1:0] POS_FLAG   = 4'd1;
   localparam logic [POS_W-1:0] POS_DATA0  = 4'd2;
   localparam logic [POS_W-1:0] POS_LAST   = 4'd15;

   localparam logic [BYTE_W-1:0] FLAG_END  = 8'd7;
   localparam int                PRED_MAX  = 4;

   typedef logic signed [COEF_W-1:0] coef_type;

   // command to the nibble decoder
   typedef struct packed {
      logic                 en;
      logic                 channel;
      logic [NIB_W-1:0]     nibble;
      logic [PRED_W-1:0]    predictor;
      logic [SHIFT_W-1:0]   shift;
   } cmd_type;

   // first tap, over 64
   function automatic coef_type coef_a(input logic [PRED_W-1:0] p);
      coef_type c;
      case (p)
         3'd1:    c = 8'sd60;
         3'd2:    c = 8'sd115;
         3'd3:    c = 8'sd98;
         3'd4:    c = 8'sd122;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

   // second tap, over 64
   function automatic coef_type coef_b(input logic [PRED_W-1:0] p);
      coef_type c;
      case (p)
         3'd2:    c = -8'sd52;
         3'd3:    c = -8'sd55;
         3'd4:    c = -8'sd60;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

endpackage

@@ hdl/vag_dec_channels.sv @@
// ----------------------------------------------------------------------------
// VAG ADPCM decoder channels
// Valid/ready interfaces for the byte input and the sample output.
// ----------------------------------------------------------------------------
interface vag_dec_req_if;
   import vag_dec_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface vag_dec_rsp_if;
   import vag_dec_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [PCM_W-1:0] pcm_sample;
   logic                    channel;
   logic [IDX_W-1:0]        sample_index;
   logic                    end_of_stream;
   logic                    last;

   modport source (output valid, output pcm_sample, output channel, output sample_index,
                   output end_of_stream, output last, input ready);
   modport sink   (input valid, input pcm_sample, input channel, input sample_index,
                   input end_of_stream, input last, output ready);
endinterface

@@ hdl/vag_dec_core.sv @@
// ----------------------------------------------------------------------------
// VAG ADPCM nibble decoder
// Per-channel history and the two-tap prediction, one sample per command.
// ----------------------------------------------------------------------------
module vag_dec_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vag_dec_pkg::cmd_type                 cmd,
   output logic signed [vag_dec_pkg::PCM_W-1:0] pcm
);
   import vag_dec_pkg::*;

   localparam int ACC_W = HIST_W + COEF_W + 1;
   localparam int OUT_W = HIST_W + 1;
   localparam logic signed [ACC_W-1:0] HistMax = ACC_W'((64'sd1 <<< (HIST_W-1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] HistMin = ACC_W'(-(64'sd1 <<< (HIST_W-1)));
   localparam logic signed [OUT_W-HIST_FRAC-1:0] PcmMax =
      (OUT_W-HIST_FRAC)'((64'sd1 <<< (PCM_W-1)) - 64'sd1);
   localparam logic signed [OUT_W-HIST_FRAC-1:0] PcmMin =
      (OUT_W-HIST_FRAC)'(-(64'sd1 <<< (PCM_W-1)));

   logic signed [HIST_W-1:0] newer_ff [2];
   logic signed [HIST_W-1:0] older_ff [2];

   logic signed [HIST_W-1:0]          h1;
   logic signed [HIST_W-1:0]          h2;
   coef_type                          ca;
   coef_type                          cb;
   logic signed [ACC_W-1:0]           acc;
   logic signed [PCM_W-1:0]           samp;
   logic signed [ACC_W-1:0]           v_full;
   logic signed [HIST_W-1:0]          v;
   logic signed [OUT_W-1:0]           t;
   logic signed [OUT_W-1:0]           t_adj;
   logic signed [OUT_W-HIST_FRAC-1:0] q;

   always_comb begin
      h1   = newer_ff[cmd.channel];
      h2   = older_ff[cmd.channel];
      ca   = coef_a(cmd.predictor);
      cb   = coef_b(cmd.predictor);
      acc  = ACC_W'(h1) * ACC_W'(ca) + ACC_W'(h2) * ACC_W'(cb);
      // nibble at the top of 16 bits, floor shift
      samp = $signed({cmd.nibble, {(PCM_W-NIB_W){1'b0}}}) >>> cmd.shift;
      v_full = (ACC_W'(samp) <<< HIST_FRAC) + (acc >>> HIST_FRAC);
      if (v_full > HistMax) begin
         v = HistMax[HIST_W-1:0];
      end else if (v_full < HistMin) begin
         v = HistMin[HIST_W-1:0];
      end else begin
         v = v_full[HIST_W-1:0];
      end
      // round half up, then divide toward zero
      t     = OUT_W'(v) + OUT_W'(32);
      t_adj = t[OUT_W-1] ? t + OUT_W'(63) : t;
      q     = (OUT_W-HIST_FRAC)'(t_adj >>> HIST_FRAC);
      if (q > PcmMax) begin
         pcm = PcmMax[PCM_W-1:0];
      end else if (q < PcmMin) begin
         pcm = PcmMin[PCM_W-1:0];
      end else begin
         pcm = q[PCM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            newer_ff[i] <= '0;
            older_ff[i] <= '0;
         end
      end else if (cmd.en) begin
         older_ff[cmd.channel] <= newer_ff[cmd.channel];
         newer_ff[cmd.channel] <= v;
      end
   end

endmodule

@@ hdl/vag_adpcm_stereo_decoder.sv @@
// ----------------------------------------------------------------------------
// VAG ADPCM stereo decoder
// Streaming 16-byte-block ADPCM decoder with alternating channel histories.
// ----------------------------------------------------------------------------
// Bytes enter on req_port, one item per byte, and decoded samples leave on
// rsp_port, one item per sample. Each 16-byte block is a header byte
// (predictor, shift), a flag byte and 14 data bytes of two samples each, low
// nibble first. Header and non-end flag bytes produce nothing; a data byte
// yields its two samples one after the other, because the single nibble
// decoder updates the channel history that the second sample reads. A flag
// byte of 7 produces one end-of-stream item and all later bytes are accepted
// and dropped until reset. Every BLOCKS_PER_CHANNEL blocks the decoder
// switches between the left and right history sets; each sample carries its
// channel and its index within that channel's region. The output register
// lets the next byte be taken while a sample waits on rsp_port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vag_adpcm_stereo_decoder #(
   parameter int BLOCKS_PER_CHANNEL = vag_dec_pkg::BLOCKS_PER_CHANNEL_DEF
) (
   input  logic         clock,
   input  logic         reset,
   vag_dec_req_if.sink   req_port,
   vag_dec_rsp_if.source rsp_port
);
   import vag_dec_pkg::*;

   localparam int BcW  = (BLOCKS_PER_CHANNEL > 1) ? $clog2(BLOCKS_PER_CHANNEL) : 1;
   localparam int BaseW = BcW + 5;
   localparam logic [BcW-1:0] BcLast = BcW'(BLOCKS_PER_CHANNEL - 1);

   // input holding register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;

   // block parser state
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [PRED_W-1:0]  pred_ff, pred_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic               chan_ff, chan_in;
   logic [BcW-1:0]     bc_ff, bc_in;
   logic               stopped_ff, stopped_in;
   logic               phase_ff, phase_in;   // 0 low nibble, 1 high nibble

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [PCM_W-1:0] pcm_ff, pcm_in;
   logic                    och_ff, och_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    eos_ff, eos_in;
   logic                    last_ff, last_in;

   logic                    is_header, is_flag, is_data, is_end;
   logic                    emits, out_free, step, consume, load;
   logic [BaseW-1:0]        idx_full;
   logic [BYTE_W/2-1:0]     hi_nib;
   cmd_type                 cmd;
   logic signed [PCM_W-1:0] core_pcm;

   vag_dec_core u_core (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .pcm   (core_pcm)
   );

   always_comb begin
      is_header = (pos_ff == POS_HEADER);
      is_flag   = (pos_ff == POS_FLAG);
      is_data   = !is_header && !is_flag;
      is_end    = is_flag && (byte_ff == FLAG_END);
      hi_nib    = byte_ff[BYTE_W-1:BYTE_W/2];

      out_free = !rsp_valid_ff || rsp_port.ready;
      emits    = in_valid_ff && !stopped_ff && (is_data || is_end);
      step     = in_valid_ff && (!emits || out_free);
      // byte retires: dropped, header/flag, or second nibble done
      consume  = step && (stopped_ff || !is_data || phase_ff);
      load     = step && emits;

      req_port.ready = !in_valid_ff || consume;

      cmd.en        = step && !stopped_ff && is_data;
      cmd.channel   = chan_ff;
      cmd.nibble    = phase_ff ? hi_nib : byte_ff[BYTE_W/2-1:0];
      cmd.predictor = pred_ff;
      cmd.shift     = shift_ff;

      idx_full = BaseW'(bc_ff) * BaseW'(SAMPLES_PER_BLOCK)
               + BaseW'({pos_ff - POS_DATA0, phase_ff});
   end

   // input register and parser next state
   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      pos_in      = pos_ff;
      pred_in     = pred_ff;
      shift_in    = shift_ff;
      chan_in     = chan_ff;
      bc_in       = bc_ff;
      stopped_in  = stopped_ff;
      phase_in    = phase_ff;

      if (consume) begin
         in_valid_in = 1'b0;
      end
      if (req_port.valid && req_port.ready) begin
         in_valid_in = 1'b1;
         byte_in     = req_port.data_byte;
      end

      if (step && !stopped_ff) begin
         if (is_header) begin
            pred_in  = (32'(hi_nib) > PRED_MAX) ? '0 : PRED_W'(hi_nib);
            shift_in = byte_ff[SHIFT_W-1:0];
            pos_in   = POS_FLAG;
         end else if (is_flag) begin
            if (is_end) begin
               stopped_in = 1'b1;
            end else begin
               pos_in = POS_DATA0;
            end
         end else if (!phase_ff) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            if (pos_ff == POS_LAST) begin
               pos_in = POS_HEADER;
               if (bc_ff == BcLast) begin
                  bc_in   = '0;
                  chan_in = !chan_ff;
               end else begin
                  bc_in = bc_ff + BcW'(1);
               end
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   // output register next state
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pcm_in       = pcm_ff;
      och_in       = och_ff;
      idx_in       = idx_ff;
      eos_in       = eos_ff;
      last_in      = last_ff;
      if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         if (is_end) begin
            pcm_in  = '0;
            och_in  = 1'b0;
            idx_in  = '0;
            eos_in  = 1'b1;
            last_in = 1'b1;
         end else begin
            pcm_in  = core_pcm;
            och_in  = chan_ff;
            idx_in  = IDX_W'(idx_full);
            eos_in  = 1'b0;
            last_in = phase_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_ff       <= POS_HEADER;
         pred_ff      <= '0;
         shift_ff     <= '0;
         chan_ff      <= 1'b0;
         bc_ff        <= '0;
         stopped_ff   <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         pred_ff      <= pred_in;
         shift_ff     <= shift_in;
         chan_ff      <= chan_in;
         bc_ff        <= bc_in;
         stopped_ff   <= stopped_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      pcm_ff  <= pcm_in;
      och_ff  <= och_in;
      idx_ff  <= idx_in;
      eos_ff  <= eos_in;
      last_ff <= last_in;
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.pcm_sample    = pcm_ff;
   assign rsp_port.channel       = och_ff;
   assign rsp_port.sample_index  = idx_ff;
   assign rsp_port.end_of_stream = eos_ff;
   assign rsp_port.last          = last_ff;

   // an end-of-stream item is always the sole, zeroed item of its byte
   `ASSERT_IMPLIES(a_eos_shape, rsp_valid_ff && eos_ff, last_ff && pcm_ff == '0 && idx_ff == '0)
   // once stopped, nothing more reaches the output register
   `ASSERT_NEVER(a_no_load_stopped, load && stopped_ff)
   // first sample of a data byte keeps the byte for its second sample
   `ASSERT_NEXT(a_lo_then_hi, load && is_data && !phase_ff, in_valid_ff && phase_ff)
   // the channel only changes on a block boundary
   `ASSERT_IMPLIES(a_chan_boundary, chan_in != chan_ff, consume && pos_ff == POS_LAST)

endmodule
